// ----- rtl/core/srs_pkg.sv -----
// shared types and constants of the spectrum linear resampler
package srs_pkg;

  localparam int unsigned CNT_W       = 13;
  localparam int unsigned IDX_W       = 12;
  localparam int unsigned PWR_W       = 32;
  localparam int unsigned ADDR_W      = 3;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned UP_SHIFT    = 6;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;

  localparam logic [CNT_W-1:0] MAX_BINS   = CNT_W'(4096);
  localparam logic [CNT_W-1:0] RESET_BINS = CNT_W'(513);

  localparam logic REG_SOURCE_BINS = 1'b0;
  localparam logic REG_DEST_BINS   = 1'b1;

  typedef enum logic [1:0] {
    KIND_ERR,
    KIND_PASS,
    KIND_FIRST,
    KIND_INTERP
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [CNT_W-1:0]  src_idx;
    logic              last_src;
    logic [PWR_W-1:0]  power;
    logic [PWR_W-1:0]  prev_power;
  } desc_t;

  typedef struct packed {
    logic              bad;
    logic              same;
    logic [CNT_W-1:0]  sm1;
    logic [CNT_W-1:0]  den;
    logic [CNT_W-1:0]  dest_bins;
  } cfg_info_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic              last;
    logic              err;
  } res_meta_t;

endpackage

// ----- rtl/core/srs_div.sv -----
// restoring divider for the per-destination-bin position step
module srs_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [srs_pkg::CNT_W-1:0]             sm1_i,
  input  logic [srs_pkg::CNT_W-1:0]             den_i,
  output logic                                  busy_o,
  output logic [srs_pkg::CNT_W+FRAC_BITS-1:0]   quo_o,
  output logic [srs_pkg::CNT_W-1:0]             rem_o
);

  localparam int unsigned DVD_W   = srs_pkg::CNT_W + FRAC_BITS;
  localparam int unsigned STEP_W  = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]          shf_q;
  logic [srs_pkg::CNT_W-1:0] rem_q;
  logic [srs_pkg::CNT_W-1:0] den_q;
  logic [STEP_W-1:0]         cnt_q;
  logic [srs_pkg::CNT_W:0]   trial;
  logic [srs_pkg::CNT_W:0]   diff;
  logic                      ge;

  assign trial  = {rem_q, shf_q[DVD_W-1]};
  assign ge     = trial >= {1'b0, den_q};
  assign diff   = trial - {1'b0, den_q};
  assign busy_o = cnt_q != '0;
  assign quo_o  = shf_q;
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= STEP_W'(DVD_W);
    end else if (busy_o) begin
      cnt_q <= cnt_q - STEP_W'(1);
    end
  end

  // one quotient bit per cycle, shifted in behind the dividend
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shf_q <= {sm1_i, {FRAC_BITS{1'b0}}};
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_o) begin
      shf_q <= {shf_q[DVD_W-2:0], ge};
      rem_q <= ge ? diff[srs_pkg::CNT_W-1:0] : trial[srs_pkg::CNT_W-1:0];
    end
  end

endmodule

// ----- rtl/core/srs_front.sv -----
// front end: tracks the source bin count and classifies each input bin
module srs_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        clear_i,
  input  logic                        accept_i,
  input  logic [srs_pkg::PWR_W-1:0]   power_i,
  input  srs_pkg::cfg_info_t          info_i,
  output srs_pkg::desc_t              desc_o
);

  logic [srs_pkg::CNT_W-1:0] src_cnt_q;
  logic [srs_pkg::PWR_W-1:0] prev_q;
  logic                      last_src;

  assign last_src = src_cnt_q >= info_i.sm1;

  always_comb begin
    desc_o.src_idx    = src_cnt_q;
    desc_o.last_src   = last_src;
    desc_o.power      = power_i;
    desc_o.prev_power = prev_q;
    if (info_i.bad) begin
      desc_o.kind = srs_pkg::KIND_ERR;
    end else if (info_i.same) begin
      desc_o.kind = srs_pkg::KIND_PASS;
    end else if (src_cnt_q == '0) begin
      desc_o.kind = srs_pkg::KIND_FIRST;
    end else begin
      desc_o.kind = srs_pkg::KIND_INTERP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_cnt_q <= '0;
      prev_q    <= '0;
    end else if (clear_i) begin
      src_cnt_q <= '0;
    end else if (accept_i) begin
      if (info_i.bad) begin
        // previous bin is kept on an unsupported ratio
        src_cnt_q <= '0;
      end else begin
        prev_q    <= power_i;
        src_cnt_q <= last_src ? '0 : src_cnt_q + srs_pkg::CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/core/srs_fifo.sv -----
// short queue of classified source bins between front and back end
module srs_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  srs_pkg::desc_t  data_i,
  input  logic            pop_i,
  output srs_pkg::desc_t  data_o,
  output logic            empty_o,
  output logic            full_o
);

  localparam logic [srs_pkg::QPTR_W:0] FULL_CNT = (srs_pkg::QPTR_W+1)'(srs_pkg::QUEUE_DEPTH);

  srs_pkg::desc_t             mem_q [srs_pkg::QUEUE_DEPTH];
  logic [srs_pkg::QPTR_W-1:0] wr_ptr_q;
  logic [srs_pkg::QPTR_W-1:0] rd_ptr_q;
  logic [srs_pkg::QPTR_W:0]   cnt_q;
  logic                       do_push;
  logic                       do_pop;

  assign empty_o = cnt_q == '0;
  assign full_o  = cnt_q == FULL_CNT;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/core/srs_back.sv -----
// back end: walks destination bins and interpolates through a three-stage pipe
module srs_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  clear_i,
  input  srs_pkg::cfg_info_t                    info_i,
  input  logic [srs_pkg::CNT_W+FRAC_BITS-1:0]   step_i,
  input  logic [srs_pkg::CNT_W-1:0]             step_rem_i,
  input  logic                                  head_valid_i,
  input  srs_pkg::desc_t                        desc_i,
  output logic                                  pop_o,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [srs_pkg::IDX_W-1:0]             bin_index_o,
  output logic [srs_pkg::PWR_W-1:0]             bin_power_o,
  output logic                                  last_bin_o,
  output logic                                  config_error_o
);

  localparam int unsigned CNT_W  = srs_pkg::CNT_W;
  localparam int unsigned PWR_W  = srs_pkg::PWR_W;
  localparam int unsigned ACC_W  = CNT_W + FRAC_BITS;
  localparam int unsigned PROD_W = PWR_W + 1 + FRAC_BITS + 1;

  // destination walk state: acc holds floor(k*(S-1)*2^F/(D-1)), err its residue
  logic [CNT_W-1:0]     dest_next_q, dest_next_d;
  logic [ACC_W-1:0]     acc_q, acc_d;
  logic [CNT_W-1:0]     err_q, err_d;

  logic                 v1_q, v2_q, v3_q;
  logic [PWR_W-1:0]     lo1_q, hi1_q, lo2_q, pwr3_q;
  logic [FRAC_BITS-1:0] a1_q;
  logic signed [PROD_W-1:0] prod2_q;
  srs_pkg::res_meta_t   meta1_q, meta2_q, meta3_q;

  logic                 adv;
  logic                 can;
  logic                 emit;
  logic [CNT_W-1:0]     lo_idx;
  logic [CNT_W:0]       hi_inc;
  logic [CNT_W-1:0]     hi_idx;
  logic                 hit;
  logic [CNT_W:0]       e_sum;
  logic                 carry;
  logic [CNT_W:0]       e_wrap;
  logic [ACC_W-1:0]     acc_next;
  logic [PWR_W-1:0]     lo_op, hi_op;
  logic [FRAC_BITS-1:0] a_op;
  srs_pkg::res_meta_t   meta_op;

  logic signed [PWR_W:0]     diff;
  logic signed [FRAC_BITS:0] a_s;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  prod_sh;
  logic [PWR_W+1:0]          sum;

  assign adv    = !v3_q || !out_stall_i;
  assign can    = adv && head_valid_i;

  assign lo_idx = acc_q[ACC_W-1:FRAC_BITS];
  assign hi_inc = {1'b0, lo_idx} + 1'b1;
  assign hi_idx = (hi_inc > {1'b0, info_i.sm1}) ? info_i.sm1 : hi_inc[CNT_W-1:0];
  assign hit    = (dest_next_q < info_i.dest_bins) && (info_i.den != '0) &&
                  (hi_idx == desc_i.src_idx);

  assign e_sum    = {1'b0, err_q} + {1'b0, step_rem_i};
  assign carry    = e_sum >= {1'b0, info_i.den};
  assign e_wrap   = carry ? e_sum - {1'b0, info_i.den} : e_sum;
  assign acc_next = acc_q + step_i + ACC_W'(carry);

  always_comb begin
    emit        = 1'b0;
    pop_o       = 1'b0;
    dest_next_d = dest_next_q;
    acc_d       = acc_q;
    err_d       = err_q;
    lo_op       = desc_i.power;
    hi_op       = desc_i.power;
    a_op        = '0;
    meta_op     = '{idx: '0, last: 1'b0, err: 1'b0};
    if (clear_i) begin
      dest_next_d = '0;
      acc_d       = '0;
      err_d       = '0;
    end else if (can) begin
      case (desc_i.kind)
        srs_pkg::KIND_ERR: begin
          emit        = 1'b1;
          pop_o       = 1'b1;
          lo_op       = '0;
          hi_op       = '0;
          meta_op.err = 1'b1;
          dest_next_d = '0;
          acc_d       = '0;
          err_d       = '0;
        end
        srs_pkg::KIND_PASS: begin
          emit         = 1'b1;
          pop_o        = 1'b1;
          meta_op.idx  = desc_i.src_idx[srs_pkg::IDX_W-1:0];
          meta_op.last = desc_i.last_src;
        end
        srs_pkg::KIND_FIRST: begin
          emit         = 1'b1;
          pop_o        = 1'b1;
          meta_op.last = info_i.den == '0;
          dest_next_d  = CNT_W'(1);
          acc_d        = step_i;
          err_d        = step_rem_i;
        end
        srs_pkg::KIND_INTERP: begin
          if (hit) begin
            emit         = 1'b1;
            lo_op        = (lo_idx == desc_i.src_idx) ? desc_i.power : desc_i.prev_power;
            a_op         = acc_q[FRAC_BITS-1:0];
            meta_op.idx  = dest_next_q[srs_pkg::IDX_W-1:0];
            meta_op.last = dest_next_q == info_i.den;
            dest_next_d  = dest_next_q + CNT_W'(1);
            acc_d        = acc_next;
            err_d        = e_wrap[CNT_W-1:0];
          end else begin
            // no more destination bins end on this source bin
            pop_o = 1'b1;
            if (desc_i.last_src) begin
              dest_next_d = '0;
              acc_d       = '0;
              err_d       = '0;
            end
          end
        end
        default: begin
          pop_o = 1'b1;
        end
      endcase
    end
  end

  // lo + (hi - lo) * a / 2^F equals the weighted sum rounded down
  assign diff    = $signed({1'b0, hi1_q}) - $signed({1'b0, lo1_q});
  assign a_s     = $signed({1'b0, a1_q});
  assign prod    = diff * a_s;
  assign prod_sh = prod2_q >>> FRAC_BITS;
  assign sum     = {2'b00, lo2_q} + prod_sh[PWR_W+1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_next_q <= '0;
      acc_q       <= '0;
      err_q       <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
    end else begin
      dest_next_q <= dest_next_d;
      acc_q       <= acc_d;
      err_q       <= err_d;
      if (adv) begin
        v1_q <= emit;
        v2_q <= v1_q;
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lo1_q   <= lo_op;
      hi1_q   <= hi_op;
      a1_q    <= a_op;
      meta1_q <= meta_op;
      lo2_q   <= lo1_q;
      prod2_q <= prod;
      meta2_q <= meta1_q;
      pwr3_q  <= sum[PWR_W-1:0];
      meta3_q <= meta2_q;
    end
  end

  assign out_valid_o    = v3_q;
  assign bin_index_o    = meta3_q.idx;
  assign bin_power_o    = pwr3_q;
  assign last_bin_o     = meta3_q.last;
  assign config_error_o = meta3_q.err;

endmodule

// ----- rtl/core/spectrum_linear_resampler.sv -----
// Linear-interpolation resampler of a power spectrum to a configured bin count.
// Source bins enter on the in channel (in_valid_i / in_stall_o), one per
// transaction, in bin order; resampled bins leave on the out channel
// (out_valid_o / out_stall_i) with index, last-bin and error flags.
// source_bins and dest_bins sit at byte addresses 0 and 4 of the APB port; a
// write restarts the profile. An accepted source bin passes through the queue
// and the interpolation pipeline registers before its first result. A
// pass-through, first or error source bin leaves the queue once the back end
// can advance; any other source bin stays at the queue head while the single
// interpolation multiplier walks the destination bins it completes, one result
// each. After reset and after each register write, a bit-serial divider
// computes the position step, and in_stall_o stays high until it is done. A
// four-entry queue separates classification from interpolation, so source bins
// keep being taken while results wait; when the receiver stalls the output
// register holds and the queue fills before in_stall_o rises. Reset clears
// counters and the previous bin, and loads 513 into both size registers.
module spectrum_linear_resampler #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [srs_pkg::ADDR_W-1:0]    paddr,
  input  logic [srs_pkg::DATA_W-1:0]    pwdata,
  output logic [srs_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [srs_pkg::PWR_W-1:0]     source_power_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [srs_pkg::IDX_W-1:0]     bin_index_o,
  output logic [srs_pkg::PWR_W-1:0]     bin_power_o,
  output logic                          last_bin_o,
  output logic                          config_error_o
);

  localparam int unsigned CNT_W = srs_pkg::CNT_W;
  localparam int unsigned ACC_W = CNT_W + FRAC_BITS;
  localparam int unsigned LIM_W = CNT_W + srs_pkg::UP_SHIFT;

  logic [CNT_W-1:0]    src_bins_q;
  logic [CNT_W-1:0]    dst_bins_q;
  logic                cfg_wr;
  logic                recalc_q;
  logic [CNT_W-1:0]    sm1;
  logic [CNT_W-1:0]    dm1;
  logic [LIM_W-1:0]    up_lim;
  srs_pkg::cfg_info_t  cfg_info_d, cfg_info_q;

  logic                div_busy;
  logic [ACC_W-1:0]    step;
  logic [CNT_W-1:0]    step_rem;

  logic                q_push;
  logic                q_pop;
  logic                q_empty;
  logic                q_full;
  srs_pkg::desc_t      front_desc;
  srs_pkg::desc_t      head_desc;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_bins_q <= srs_pkg::RESET_BINS;
      dst_bins_q <= srs_pkg::RESET_BINS;
    end else if (cfg_wr) begin
      case (paddr[2])
        srs_pkg::REG_SOURCE_BINS: src_bins_q <= pwdata[CNT_W-1:0];
        srs_pkg::REG_DEST_BINS:   dst_bins_q <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      srs_pkg::REG_SOURCE_BINS: prdata = srs_pkg::DATA_W'(src_bins_q);
      srs_pkg::REG_DEST_BINS:   prdata = srs_pkg::DATA_W'(dst_bins_q);
      default:                  prdata = '0;
    endcase
  end

  // ratio check: D-1 may be at most 63*(S-1) when the sizes differ
  assign sm1    = src_bins_q - CNT_W'(1);
  assign dm1    = dst_bins_q - CNT_W'(1);
  assign up_lim = {sm1, {srs_pkg::UP_SHIFT{1'b0}}} - LIM_W'(sm1);

  always_comb begin
    cfg_info_d.same      = src_bins_q == dst_bins_q;
    cfg_info_d.sm1       = sm1;
    cfg_info_d.den       = dm1;
    cfg_info_d.dest_bins = dst_bins_q;
    cfg_info_d.bad       = (src_bins_q == '0) || (dst_bins_q == '0) ||
                           (src_bins_q > srs_pkg::MAX_BINS) ||
                           (dst_bins_q > srs_pkg::MAX_BINS) ||
                           (!cfg_info_d.same &&
                            ((src_bins_q < CNT_W'(2)) || (LIM_W'(dm1) > up_lim)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_info_q <= '0;
      recalc_q   <= 1'b1;
    end else begin
      cfg_info_q <= cfg_info_d;
      recalc_q   <= cfg_wr;
    end
  end

  srs_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (recalc_q),
    .sm1_i   (sm1),
    .den_i   (dm1),
    .busy_o  (div_busy),
    .quo_o   (step),
    .rem_o   (step_rem)
  );

  assign in_stall_o = recalc_q || div_busy || q_full;
  assign q_push     = in_valid_i && !in_stall_o;

  srs_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (cfg_wr),
    .accept_i (q_push),
    .power_i  (source_power_i),
    .info_i   (cfg_info_q),
    .desc_o   (front_desc)
  );

  srs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (front_desc),
    .pop_i   (q_pop),
    .data_o  (head_desc),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  srs_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .clear_i        (cfg_wr),
    .info_i         (cfg_info_q),
    .step_i         (step),
    .step_rem_i     (step_rem),
    .head_valid_i   (!q_empty),
    .desc_i         (head_desc),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .bin_index_o    (bin_index_o),
    .bin_power_o    (bin_power_o),
    .last_bin_o     (last_bin_o),
    .config_error_o (config_error_o)
  );

`ifndef SYNTHESIS
  a_err_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && config_error_o |->
      bin_power_o == '0 && bin_index_o == '0 && !last_bin_o)
    else $error("error result carries a non-zero payload");

  a_last_is_final_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_bin_o && !config_error_o && !cfg_info_q.same |->
      bin_index_o == cfg_info_q.den[srs_pkg::IDX_W-1:0])
    else $error("last bin flagged on a bin other than the final one");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("back end took a source bin from an empty queue");
`endif

endmodule
